// ----- rtl/mat4_vec4_float_transform_core_assert.svh -----
// Assertion macros shared by the matrix-vector transform RTL
`ifndef MAT4_VEC4_FLOAT_TRANSFORM_CORE_ASSERT_SVH
`define MAT4_VEC4_FLOAT_TRANSFORM_CORE_ASSERT_SVH

// same-cycle implication, reset disables the check
`define MVT_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset disables the check
`define MVT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mvt_pkg.sv -----
// Package for the matrix-vector transform: types, constants and float helpers
`default_nettype none

package mvt_pkg;

	localparam int unsigned NUM_REGS   = 8;
	localparam int unsigned CFG_IDX_W  = 4;
	localparam int unsigned CFG_DATA_W = 64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_C01 = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_C23 = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_C01 = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_C23 = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_C01 = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_C23 = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_C01 = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_ROW3_C23 = 4'd7;

	// reset values give the identity matrix
	localparam logic [CFG_DATA_W-1:0] RST_ONE_LO = 64'h0000_0000_3F80_0000;
	localparam logic [CFG_DATA_W-1:0] RST_ONE_HI = 64'h3F80_0000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] RST_ZERO   = 64'h0;

	localparam logic [31:0] QNAN = 32'h7FC0_0000;

	// pipeline depths
	localparam int unsigned MUL_STAGES = 4;
	localparam int unsigned ADD_STAGES = 5;
	localparam int unsigned PIPE_LAT   = MUL_STAGES + 2 * ADD_STAGES;

	typedef struct packed {
		logic [31:0] vec_x;
		logic [31:0] vec_y;
		logic [31:0] vec_z;
		logic [31:0] vec_w;
	} vec_item_t;

	typedef struct packed {
		logic [31:0] out_x;
		logic [31:0] out_y;
		logic [31:0] out_z;
		logic [31:0] out_w;
	} res_item_t;

	// special-case flags carried down a float pipeline
	typedef struct packed {
		logic is_nan;
		logic is_inf;
		logic sign;
	} fp_spec_t;

	// leading zeros of a 48-bit word
	function automatic logic [5:0] clz48(input logic [47:0] v);
		logic [5:0] n;
		logic       found;
		n = 6'd48;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 6'(47 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// leading zeros of a 28-bit word
	function automatic logic [4:0] clz28(input logic [27:0] v);
		logic [4:0] n;
		logic       found;
		n = 5'd28;
		found = 1'b0;
		for (int i = 27; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 5'(27 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	// round to nearest even and pack; e >= 1, a clear m[23] means subnormal
	function automatic logic [31:0] fp_round_pack(input logic sign, input logic [9:0] e,
			input logic [23:0] m, input logic g, input logic st);
		logic        inc;
		logic [24:0] mr;
		logic [23:0] mf;
		logic [9:0]  ef;
		logic [31:0] r;
		inc = g & (st | m[0]);
		mr = {1'b0, m} + 25'(inc);
		if (mr[24]) begin
			mf = mr[24:1];
			ef = e + 10'd1;
		end else begin
			mf = mr[23:0];
			ef = e;
		end
		if (ef >= 10'd255) begin
			r = {sign, 8'hFF, 23'd0};
		end else begin
			r = {sign, (mf[23] ? ef[7:0] : 8'd0), mf[22:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/mvt_fmul.sv -----
// Four-stage binary32 multiplier with subnormal support
`default_nettype none

module mvt_fmul import mvt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_vld,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic             out_vld,
	output logic [31:0]      y
);

	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	fp_spec_t          spec_s1, spec_s2, spec_s3;
	logic [47:0]       prod_s1, prod_s2;
	logic signed [10:0] esum_s1;
	logic signed [10:0] sh_s2;
	logic [9:0]        exp_s2, exp_s3;
	logic              zero_s2, zero_s3;
	logic [23:0]       man_s3;
	logic              g_s3, st_s3;
	logic [31:0]       y_s4;

	// unpack and special cases
	logic [23:0] a_man, b_man;
	logic [7:0]  a_e, b_e;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	fp_spec_t    spec_c;

	always_comb begin
		a_man  = {|a[30:23], a[22:0]};
		b_man  = {|b[30:23], b[22:0]};
		a_e    = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		b_e    = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		a_nan  = (&a[30:23]) & (|a[22:0]);
		b_nan  = (&b[30:23]) & (|b[22:0]);
		a_inf  = (&a[30:23]) & ~(|a[22:0]);
		b_inf  = (&b[30:23]) & ~(|b[22:0]);
		a_zero = (a[30:0] == 31'd0);
		b_zero = (b[30:0] == 31'd0);
		spec_c.is_nan = a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
		spec_c.is_inf = (a_inf | b_inf) & ~spec_c.is_nan;
		spec_c.sign   = a[31] ^ b[31];
	end

	// stage 1: mantissa product and exponent sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a_man * b_man;
		esum_s1 <= $signed({3'b0, a_e}) + $signed({3'b0, b_e}) - 11'sd126;
		spec_s1 <= spec_c;
	end

	// stage 2: leading-zero count, exponent and shift
	logic [5:0]         lz;
	logic signed [10:0] e0;
	logic signed [10:0] sh_c;
	logic [9:0]         exp_c;

	always_comb begin
		lz = clz48(prod_s1);
		e0 = esum_s1 - $signed({5'b0, lz});
		if (e0 < 11'sd1) begin
			sh_c  = esum_s1 - 11'sd1;
			exp_c = 10'd1;
		end else begin
			sh_c  = $signed({5'b0, lz});
			exp_c = e0[9:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_s1;
		sh_s2   <= sh_c;
		exp_s2  <= exp_c;
		zero_s2 <= (prod_s1 == 48'd0);
		spec_s2 <= spec_s1;
	end

	// stage 3: normalize left, or denormalize right with sticky
	logic [6:0]  rs;
	logic [47:0] norm;
	logic        rsticky;

	always_comb begin
		rs = 7'(11'sd0 - sh_s2);
		if (sh_s2 >= 11'sd0) begin
			norm    = prod_s2 << sh_s2[5:0];
			rsticky = 1'b0;
		end else begin
			norm    = prod_s2 >> rs;
			rsticky = |(prod_s2 & ~({48{1'b1}} << rs));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		man_s3  <= norm[47:24];
		g_s3    <= norm[23];
		st_s3   <= (|norm[22:0]) | rsticky;
		exp_s3  <= exp_s2;
		zero_s3 <= zero_s2;
		spec_s3 <= spec_s2;
	end

	// stage 4: round and pack
	logic [31:0] y_c;

	always_comb begin
		if (spec_s3.is_nan) begin
			y_c = QNAN;
		end else if (spec_s3.is_inf) begin
			y_c = {spec_s3.sign, 8'hFF, 23'd0};
		end else if (zero_s3) begin
			y_c = {spec_s3.sign, 31'd0};
		end else begin
			y_c = fp_round_pack(spec_s3.sign, exp_s3, man_s3, g_s3, st_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		y_s4 <= y_c;
	end

	assign out_vld = vld_s4;
	assign y       = y_s4;

endmodule

`default_nettype wire

// ----- rtl/mvt_fadd.sv -----
// Five-stage binary32 adder with subnormal support
`default_nettype none

module mvt_fadd import mvt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_vld,
	input  wire logic [31:0] a,
	input  wire logic [31:0] b,
	output logic             out_vld,
	output logic [31:0]      y
);

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	fp_spec_t    spec_s1, spec_s2, spec_s3, spec_s4;
	logic        sub_s1, sub_s2, sub_s3, sub_s4;
	logic [23:0] bm_s1, sm_s1;
	logic [7:0]  be_s1, be_s2;
	logic [7:0]  d_s1;
	logic        bsign_s1, bsign_s2, bsign_s3, bsign_s4;
	logic [27:0] sum_s2, sum_s3;
	logic [4:0]  sh_s3;
	logic        right_s3;
	logic [9:0]  exp_s3, exp_s4;
	logic        zero_s3, zero_s4;
	logic [23:0] man_s4;
	logic        g_s4, st_s4;
	logic [31:0] y_s5;

	// unpack, specials, order by magnitude
	logic        a_nan, b_nan, a_inf, b_inf, swap;
	logic [31:0] big, sml;
	fp_spec_t    spec_c;

	always_comb begin
		a_nan = (&a[30:23]) & (|a[22:0]);
		b_nan = (&b[30:23]) & (|b[22:0]);
		a_inf = (&a[30:23]) & ~(|a[22:0]);
		b_inf = (&b[30:23]) & ~(|b[22:0]);
		spec_c.is_nan = a_nan | b_nan | (a_inf & b_inf & (a[31] ^ b[31]));
		spec_c.is_inf = (a_inf | b_inf) & ~spec_c.is_nan;
		spec_c.sign   = a_inf ? a[31] : b[31];
		swap = (b[30:0] > a[30:0]);
		big  = swap ? b : a;
		sml  = swap ? a : b;
	end

	// stage 1: operands in order, exponent difference
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		bm_s1    <= {|big[30:23], big[22:0]};
		sm_s1    <= {|sml[30:23], sml[22:0]};
		be_s1    <= (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		d_s1     <= ((big[30:23] == 8'd0) ? 8'd1 : big[30:23])
			- ((sml[30:23] == 8'd0) ? 8'd1 : sml[30:23]);
		bsign_s1 <= big[31];
		sub_s1   <= a[31] ^ b[31];
		spec_s1  <= spec_c;
	end

	// stage 2: align smaller operand with sticky, then add or subtract
	logic [26:0] sext, al;
	logic        ast;
	logic [27:0] sum_c;

	always_comb begin
		sext = {sm_s1, 3'b000};
		if (d_s1 >= 8'd27) begin
			al  = 27'd0;
			ast = |sm_s1;
		end else begin
			al  = sext >> d_s1[4:0];
			ast = |(sext & ~({27{1'b1}} << d_s1[4:0]));
		end
		al[0] = al[0] | ast;
		if (sub_s1) begin
			sum_c = {1'b0, bm_s1, 3'b000} - {1'b0, al};
		end else begin
			sum_c = {1'b0, bm_s1, 3'b000} + {1'b0, al};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2   <= sum_c;
		be_s2    <= be_s1;
		bsign_s2 <= bsign_s1;
		sub_s2   <= sub_s1;
		spec_s2  <= spec_s1;
	end

	// stage 3: leading zeros and normalize amount, held at the subnormal floor
	logic [4:0] lz;
	logic [8:0] lzz, emax;
	logic [4:0] sh_c;
	logic [9:0] exp_c;

	always_comb begin
		lz   = clz28(sum_s2);
		lzz  = 9'(lz) - 9'd1;
		emax = 9'(be_s2) - 9'd1;
		if (sum_s2[27]) begin
			sh_c  = 5'd0;
			exp_c = 10'(be_s2) + 10'd1;
		end else if (lzz < emax) begin
			sh_c  = lzz[4:0];
			exp_c = 10'(be_s2) - 10'(lzz);
		end else begin
			sh_c  = emax[4:0];
			exp_c = 10'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		sum_s3   <= sum_s2;
		sh_s3    <= sh_c;
		right_s3 <= sum_s2[27];
		exp_s3   <= exp_c;
		zero_s3  <= (sum_s2 == 28'd0);
		bsign_s3 <= bsign_s2;
		sub_s3   <= sub_s2;
		spec_s3  <= spec_s2;
	end

	// stage 4: normalizing shift
	logic [26:0] norm;

	always_comb begin
		if (right_s3) begin
			norm = {sum_s3[27:2], sum_s3[1] | sum_s3[0]};
		end else begin
			norm = sum_s3[26:0] << sh_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		man_s4   <= norm[26:3];
		g_s4     <= norm[2];
		st_s4    <= |norm[1:0];
		exp_s4   <= exp_s3;
		zero_s4  <= zero_s3;
		bsign_s4 <= bsign_s3;
		sub_s4   <= sub_s3;
		spec_s4  <= spec_s3;
	end

	// stage 5: round and pack; exact cancellation gives +0
	logic [31:0] y_c;

	always_comb begin
		if (spec_s4.is_nan) begin
			y_c = QNAN;
		end else if (spec_s4.is_inf) begin
			y_c = {spec_s4.sign, 8'hFF, 23'd0};
		end else if (zero_s4) begin
			y_c = {bsign_s4 & ~sub_s4, 31'd0};
		end else begin
			y_c = fp_round_pack(bsign_s4, exp_s4, man_s4, g_s4, st_s4);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		y_s5 <= y_c;
	end

	assign out_vld = vld_s5;
	assign y       = y_s5;

endmodule

`default_nettype wire

// ----- rtl/mvt_row.sv -----
// One row dot product: four multipliers and a two-level adder tree
`default_nettype none

module mvt_row import mvt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_vld,
	input  wire logic [63:0] c01,
	input  wire logic [63:0] c23,
	input  wire vec_item_t   v,
	output logic             out_vld,
	output logic [31:0]      y
);

	logic [31:0] p0, p1, p2, p3;
	logic [31:0] s01, s23;
	logic        p_vld, s_vld;

	// products
	mvt_fmul u_mul0 (
		.clk(clk), .arst_n(arst_n), .in_vld(in_vld),
		.a(c01[31:0]), .b(v.vec_x), .out_vld(p_vld), .y(p0)
	);
	mvt_fmul u_mul1 (
		.clk(clk), .arst_n(arst_n), .in_vld(in_vld),
		.a(c01[63:32]), .b(v.vec_y), .out_vld(), .y(p1)
	);
	mvt_fmul u_mul2 (
		.clk(clk), .arst_n(arst_n), .in_vld(in_vld),
		.a(c23[31:0]), .b(v.vec_z), .out_vld(), .y(p2)
	);
	mvt_fmul u_mul3 (
		.clk(clk), .arst_n(arst_n), .in_vld(in_vld),
		.a(c23[63:32]), .b(v.vec_w), .out_vld(), .y(p3)
	);

	// (p0 + p1) and (p2 + p3)
	mvt_fadd u_add01 (
		.clk(clk), .arst_n(arst_n), .in_vld(p_vld),
		.a(p0), .b(p1), .out_vld(s_vld), .y(s01)
	);
	mvt_fadd u_add23 (
		.clk(clk), .arst_n(arst_n), .in_vld(p_vld),
		.a(p2), .b(p3), .out_vld(), .y(s23)
	);

	// final sum
	mvt_fadd u_add_all (
		.clk(clk), .arst_n(arst_n), .in_vld(s_vld),
		.a(s01), .b(s23), .out_vld(out_vld), .y(y)
	);

endmodule

`default_nettype wire

// ----- rtl/mat4_vec4_float_transform_core.sv -----
// Done pulses once the start taken at an edge has passed the 4 multiply stages and the 2x5 add stages.
// Throughput: one vector per cycle, every cycle; busy is low whenever out of reset.
// Results come as a one-cycle done strobe with result; the receiver cannot stall.
// Reset clears the pipeline valid bits and loads the identity matrix; busy is high in reset.
// The user must write matrix registers with wr_en only while no transfer is in flight; the core does not check this.
`default_nettype none

`include "mat4_vec4_float_transform_core_assert.svh"

module mat4_vec4_float_transform_core import mvt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire vec_item_t             item,
	output logic                       done,
	output res_item_t                  result,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data
);

	logic [CFG_DATA_W-1:0] mat_q [NUM_REGS];
	logic [31:0]           row_y [4];
	logic [3:0]            row_vld;
	logic                  accept;

	assign busy   = ~arst_n;
	assign accept = start & ~busy;

	// matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= RST_ONE_LO;
			mat_q[1] <= RST_ZERO;
			mat_q[2] <= RST_ONE_HI;
			mat_q[3] <= RST_ZERO;
			mat_q[4] <= RST_ZERO;
			mat_q[5] <= RST_ONE_LO;
			mat_q[6] <= RST_ZERO;
			mat_q[7] <= RST_ONE_HI;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROW0_C01: mat_q[0] <= wr_data;
				REG_ROW0_C23: mat_q[1] <= wr_data;
				REG_ROW1_C01: mat_q[2] <= wr_data;
				REG_ROW1_C23: mat_q[3] <= wr_data;
				REG_ROW2_C01: mat_q[4] <= wr_data;
				REG_ROW2_C23: mat_q[5] <= wr_data;
				REG_ROW3_C01: mat_q[6] <= wr_data;
				REG_ROW3_C23: mat_q[7] <= wr_data;
				default: ;
			endcase
		end
	end

	// one dot-product lane per row
	for (genvar r = 0; r < 4; r++) begin : g_row
		mvt_row u_row (
			.clk(clk), .arst_n(arst_n), .in_vld(accept),
			.c01(mat_q[2*r]), .c23(mat_q[2*r+1]), .v(item),
			.out_vld(row_vld[r]), .y(row_y[r])
		);
	end

	assign done          = row_vld[0];
	assign result.out_x  = row_y[0];
	assign result.out_y  = row_y[1];
	assign result.out_z  = row_y[2];
	assign result.out_w  = row_y[3];

	// checks
	`MVT_ASSERT_SAME(a_lat_fwd, clk, arst_n, accept, ##PIPE_LAT done, "transfer lost in pipeline")
	`MVT_ASSERT_SAME(a_lat_bwd, clk, arst_n, done, $past(accept, PIPE_LAT), "result without transfer")
	`MVT_ASSERT_SAME(a_lanes, clk, arst_n, row_vld != 4'd0, row_vld == 4'hF, "row lanes out of step")
	`MVT_ASSERT_SAME(a_nan_x, clk, arst_n, done && (&result.out_x[30:23]) && (|result.out_x[22:0]), result.out_x == QNAN, "NaN not canonical")
	`MVT_ASSERT_NEXT(a_no_busy, clk, arst_n, 1'b1, !busy, "busy out of reset")

endmodule

`default_nettype wire

// ----- tb/mvt_checker.sv -----
// Checker for the matrix-vector transform: tracks the matrix, predicts each result, compares
`timescale 1ns / 1ps

module mvt_checker import mvt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire vec_item_t             item,
	input  wire logic                  done,
	input  wire res_item_t             result,
	input  wire logic                  wr_en,
	input  wire logic [CFG_IDX_W-1:0]  wr_index,
	input  wire logic [CFG_DATA_W-1:0] wr_data,
	output int                         err_count,
	output int                         pending
);

	logic [CFG_DATA_W-1:0] mat_regs [NUM_REGS];
	res_item_t             exp_results [$];

	// binary32 pattern to binary64 pattern, exact
	function automatic logic [63:0] sp_to_dp(input logic [31:0] b);
		logic [22:0] f;
		logic [23:0] m;
		int          e;
		f = b[22:0];
		if (b[30:23] == 8'hFF)
			return (f != 0) ? 64'h7FF8_0000_0000_0000 : {b[31], 11'h7FF, 52'd0};
		if (b[30:23] == 8'd0) begin
			if (f == 0)
				return {b[31], 63'd0};
			m = {1'b0, f};
			e = 1;
			while (!m[23]) begin
				m = m << 1;
				e--;
			end
		end else begin
			m = {1'b1, f};
			e = int'(b[30:23]);
		end
		return {b[31], 11'(e - 127 + 1023), m[22:0], 29'd0};
	endfunction

	// binary64 pattern to binary32, round to nearest even, subnormals kept
	function automatic logic [31:0] dp_to_sp(input logic [63:0] d);
		logic [63:0] m;
		logic [63:0] kept;
		logic [63:0] r;
		logic        g;
		logic        st;
		int          fe;
		int          sh;
		if (d[62:52] == 11'h7FF)
			return (d[51:0] != 0) ? QNAN : {d[63], 8'hFF, 23'd0};
		if (d[62:52] == 11'd0)
			return {d[63], 31'd0};
		m = {11'd0, 1'b1, d[51:0]};
		fe = int'(d[62:52]) - 1023 + 127;
		sh = (fe >= 1) ? 29 : 29 + 1 - fe;
		if (sh >= 55)
			return {d[63], 31'd0};
		kept = m >> sh;
		g = m[sh-1];
		st = |(m & ((64'd1 << (sh - 1)) - 64'd1));
		kept = kept + 64'(g & (st | kept[0]));
		r = ((fe >= 1) ? (64'(fe - 1) << 23) : 64'd0) + kept;
		if (r >= 64'h7F80_0000)
			r = 64'h7F80_0000;
		return {d[63], r[30:0]};
	endfunction

	function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
		return dp_to_sp($realtobits($bitstoreal(sp_to_dp(a)) * $bitstoreal(sp_to_dp(b))));
	endfunction

	function automatic logic [31:0] sp_add(input logic [31:0] a, input logic [31:0] b);
		return dp_to_sp($realtobits($bitstoreal(sp_to_dp(a)) + $bitstoreal(sp_to_dp(b))));
	endfunction

	// one row dotted with the vector, paired sums
	function automatic logic [31:0] row_dot(input logic [63:0] c01, input logic [63:0] c23,
			input vec_item_t v);
		logic [31:0] p0, p1, p2, p3;
		p0 = sp_mul(c01[31:0], v.vec_x);
		p1 = sp_mul(c01[63:32], v.vec_y);
		p2 = sp_mul(c23[31:0], v.vec_z);
		p3 = sp_mul(c23[63:32], v.vec_w);
		return sp_add(sp_add(p0, p1), sp_add(p2, p3));
	endfunction

	function automatic res_item_t transform(input vec_item_t v);
		res_item_t r;
		r.out_x = row_dot(mat_regs[0], mat_regs[1], v);
		r.out_y = row_dot(mat_regs[2], mat_regs[3], v);
		r.out_z = row_dot(mat_regs[4], mat_regs[5], v);
		r.out_w = row_dot(mat_regs[6], mat_regs[7], v);
		return r;
	endfunction

	assign pending = exp_results.size();

	always @(posedge clk or negedge arst_n) begin
		res_item_t exp_r;
		if (!arst_n) begin
			mat_regs[REG_ROW0_C01] <= RST_ONE_LO;
			mat_regs[REG_ROW0_C23] <= RST_ZERO;
			mat_regs[REG_ROW1_C01] <= RST_ONE_HI;
			mat_regs[REG_ROW1_C23] <= RST_ZERO;
			mat_regs[REG_ROW2_C01] <= RST_ZERO;
			mat_regs[REG_ROW2_C23] <= RST_ONE_LO;
			mat_regs[REG_ROW3_C01] <= RST_ZERO;
			mat_regs[REG_ROW3_C23] <= RST_ONE_HI;
			exp_results.delete();
			err_count <= 0;
		end else begin
			// input transfer: predict with the current matrix
			if (start && !busy)
				exp_results.push_back(transform(item));
			if (wr_en && wr_index < NUM_REGS)
				mat_regs[wr_index] <= wr_data;
			// result transfer
			if (done) begin
				if (exp_results.size() == 0) begin
					$error("result with nothing expected: %h", result);
					err_count <= err_count + 1;
				end else begin
					exp_r = exp_results.pop_front();
					if (exp_r != result) begin
						if (exp_r.out_x != result.out_x)
							$error("out_x expected %h actual %h", exp_r.out_x, result.out_x);
						if (exp_r.out_y != result.out_y)
							$error("out_y expected %h actual %h", exp_r.out_y, result.out_y);
						if (exp_r.out_z != result.out_z)
							$error("out_z expected %h actual %h", exp_r.out_z, result.out_z);
						if (exp_r.out_w != result.out_w)
							$error("out_w expected %h actual %h", exp_r.out_w, result.out_w);
						err_count <= err_count + 1;
					end
				end
			end
		end
	end

endmodule

// ----- tb/tb_top.sv -----
// Testbench top for the matrix-vector transform: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;
	import mvt_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	vec_item_t             item;
	logic                  done;
	res_item_t             result;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	int                    err_count;
	int                    pending;
	int                    idle_pct;

	mat4_vec4_float_transform_core u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	mvt_checker u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.err_count(err_count), .pending(pending)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// binary32 value biased toward special encodings
	function automatic logic [31:0] rand_fp();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(0, 11))
			0: r = {r[31], 31'd0};
			1: r = {r[31], 8'hFF, 23'd0};
			2: r = {r[31], 8'hFF, r[22:0] | 23'd1};
			3: r = {r[31], 8'd0, r[22:0]};
			4: r = {r[31], 8'hFE, r[22:0]};
			5: r = {r[31], 8'd127, 23'd0};
			6, 7, 8: r = {r[31], 8'(r[30:23] % 40 + 108), r[22:0]};
			default: ;
		endcase
		return r;
	endfunction

	task automatic send_vec(input vec_item_t v);
		start <= 1'b1;
		item <= v;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic maybe_idle();
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 3))
				@(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 4)
			@(posedge clk);
	endtask

	// wr_en stays high; the caller drops it after the last write of a burst
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
	endtask

	// mode 0 random fp elements, 1 raw bits, 2 all ones, 3 all zero
	task automatic load_matrix(input int mode);
		logic [63:0] v;
		for (int i = 0; i < NUM_REGS; i++) begin
			case (mode)
				0: v = {rand_fp(), rand_fp()};
				1: v = {$urandom, $urandom};
				2: v = '1;
				default: v = '0;
			endcase
			write_reg(CFG_IDX_W'(i), v);
		end
		// out-of-range index must be ignored
		write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, 15)), {$urandom, $urandom});
		wr_en <= 1'b0;
	endtask

	function automatic vec_item_t rand_vec(input bit raw);
		vec_item_t v;
		if (raw)
			v = {$urandom, $urandom, $urandom, $urandom};
		else
			v = {rand_fp(), rand_fp(), rand_fp(), rand_fp()};
		return v;
	endfunction

	initial begin
		vec_item_t dir_vecs [$];
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		idle_pct = 16;
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed vectors on the identity matrix
		dir_vecs = '{
			'{32'h0, 32'h8000_0000, 32'h0, 32'h8000_0000},
			'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
			'{32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4080_0000},
			'{32'h7F80_0000, 32'hFF80_0000, 32'h0000_0001, 32'h807F_FFFF},
			'{32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0080_0000},
			'{32'h7FC0_0001, 32'hFFBF_FFFF, 32'h7F80_0001, 32'h3F80_0000},
			'{32'h0000_0001, 32'h0040_0000, 32'h007F_FFFF, 32'h8000_0001}
		};
		foreach (dir_vecs[i])
			send_vec(dir_vecs[i]);
		drain();

		// matrix with inf, NaN, max and subnormal entries: inf*0 and inf-inf
		write_reg(REG_ROW0_C01, {32'h7F80_0000, 32'h7F80_0000});
		write_reg(REG_ROW0_C23, {32'hFF80_0000, 32'h3F80_0000});
		write_reg(REG_ROW1_C01, {32'h7F7F_FFFF, 32'h7F7F_FFFF});
		write_reg(REG_ROW1_C23, {32'h7F7F_FFFF, 32'h7F7F_FFFF});
		write_reg(REG_ROW2_C01, {32'h0000_0001, 32'h8000_0001});
		write_reg(REG_ROW2_C23, {32'h3F00_0000, 32'h0080_0000});
		write_reg(REG_ROW3_C01, {32'h7FC0_0000, 32'h3F80_0000});
		write_reg(REG_ROW3_C23, {32'h3F80_0001, 32'hBF80_0000});
		wr_en <= 1'b0;
		foreach (dir_vecs[i])
			send_vec(dir_vecs[i]);
		send_vec('{32'h0, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000});
		send_vec('{32'h3F00_0000, 32'h3F00_0000, 32'h3F00_0000, 32'h3F00_0000});
		send_vec('{32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000});
		drain();

		// random phases through several matrix settings
		for (int ph = 0; ph < 7; ph++) begin
			load_matrix((ph == 2) ? 2 : (ph == 5) ? 3 : (ph % 2));
			idle_pct = (ph == 1) ? 0 : 16;
			for (int n = 0; n < 200; n++) begin
				maybe_idle();
				send_vec(rand_vec($urandom_range(0, 3) == 0));
				if (ph == 3 && n == 100)
					drain();
			end
			drain();
		end

		if (err_count == 0)
			$display("mat4_vec4_float_transform_core test passed");
		else
			$display("mat4_vec4_float_transform_core test failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("mat4_vec4_float_transform_core test failed");
		$finish;
	end

endmodule

// ----- mat4_vec4_float_transform_core.f -----
+incdir+rtl
rtl/mvt_pkg.sv
rtl/mvt_fmul.sv
rtl/mvt_fadd.sv
rtl/mvt_row.sv
rtl/mat4_vec4_float_transform_core.sv
tb/mvt_checker.sv
tb/tb_top.sv
